[sv/bllca_pkg.sv]
// Shared types and constants for the binary-lifting LCA table.
package bllca_pkg;

  // Field widths fixed by the request and result formats
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 11;

  // Depth saturates here
  localparam logic [DEPTH_W-1:0] DEPTH_CAP = 11'd1024;

  // Request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_t;

  // One request
  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] other_node;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [NODE_W-1:0]  ancestor;
    logic [DEPTH_W-1:0] ancestor_depth;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_LRD,
    ST_INS_LWR,
    ST_Q_DU,
    ST_Q_DV,
    ST_Q_ORD,
    ST_Q_LIFT,
    ST_Q_CHK,
    ST_Q_JOINT,
    ST_Q_FIN,
    ST_Q_RGET,
    ST_DEP,
    ST_OUT
  } st_t;

endpackage

[sv/bllca_depth_mem.sv]
// Depth memory: one write port, one registered read port, node 0 reads as zero.
module bllca_depth_mem #(
  parameter int NODES = 1024,
  localparam int AW = $clog2(NODES)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [bllca_pkg::DEPTH_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [bllca_pkg::DEPTH_W-1:0] rdata
);
  import bllca_pkg::*;

  logic [DEPTH_W-1:0] mem [NODES];
  logic [DEPTH_W-1:0] rdata_r;
  logic               rzero_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the sentinel entry is never written, so force it to zero
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    rzero_r <= (raddr == '0);
  end

  assign rdata = rzero_r ? '0 : rdata_r;

endmodule

[sv/bllca_anc_mem.sv]
// Ancestor table memory: one write port, two registered read ports, row 0 reads as zero.
module bllca_anc_mem #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  localparam int AW = $clog2(NODES),
  localparam int KW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int MW = AW + KW
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [MW-1:0]               waddr,
  input  logic [bllca_pkg::NODE_W-1:0] wdata,
  input  logic [MW-1:0]               raddr_a,
  output logic [bllca_pkg::NODE_W-1:0] rdata_a,
  input  logic [MW-1:0]               raddr_b,
  output logic [bllca_pkg::NODE_W-1:0] rdata_b
);
  import bllca_pkg::*;

  localparam int DEPTH = NODES << KW;

  logic [NODE_W-1:0] mem [DEPTH];
  logic [NODE_W-1:0] rdata_a_r;
  logic [NODE_W-1:0] rdata_b_r;
  logic              rzero_a_r;
  logic              rzero_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports; sentinel row is never written and reads as zero
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
    rzero_a_r <= (raddr_a[MW-1:KW] == '0);
    rzero_b_r <= (raddr_b[MW-1:KW] == '0);
  end

  assign rdata_a = rzero_a_r ? '0 : rdata_a_r;
  assign rdata_b = rzero_b_r ? '0 : rdata_b_r;

endmodule

[sv/bllca_ctrl.sv]
// Sequencer and datapath: insert fill walk, query lift walks, result register.
module bllca_ctrl #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  localparam int AW = $clog2(NODES),
  localparam int KW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int MW = AW + KW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bllca_pkg::in_item_t           in_item,
  output logic                          out_valid,
  output bllca_pkg::out_item_t          out_item,
  // depth memory
  output logic                          dm_we,
  output logic [AW-1:0]                 dm_waddr,
  output logic [bllca_pkg::DEPTH_W-1:0] dm_wdata,
  output logic [AW-1:0]                 dm_raddr,
  input  logic [bllca_pkg::DEPTH_W-1:0] dm_rdata,
  // ancestor memory
  output logic                          am_we,
  output logic [MW-1:0]                 am_waddr,
  output logic [bllca_pkg::NODE_W-1:0]  am_wdata,
  output logic [MW-1:0]                 am_raddr_a,
  input  logic [bllca_pkg::NODE_W-1:0]  am_rdata_a,
  output logic [MW-1:0]                 am_raddr_b,
  input  logic [bllca_pkg::NODE_W-1:0]  am_rdata_b
);
  import bllca_pkg::*;

  localparam logic [KW-1:0] K_TOP = KW'(LEVELS - 1);

  st_t                state_r, state_nxt;
  logic [NODE_W-1:0]  a_r, a_nxt;
  logic [NODE_W-1:0]  b_r, b_nxt;
  logic [NODE_W-1:0]  hi_r, hi_nxt;
  logic [NODE_W-1:0]  lo_r, lo_nxt;
  logic [NODE_W-1:0]  r_r, r_nxt;
  logic [DEPTH_W-1:0] du_r, du_nxt;
  logic [DEPTH_W-1:0] d_r, d_nxt;
  logic [LEVELS-1:0]  diff_r, diff_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic               pend_r, pend_nxt;
  logic               dsel_r, dsel_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [NODE_W-1:0]  a_in, b_in;
  logic [NODE_W-1:0]  hi_cur, lo_cur;
  logic               lift_take, joint_take;
  logic [DEPTH_W-1:0] d_ins;

  function automatic logic [MW-1:0] anc_addr(logic [NODE_W-1:0] node, logic [KW-1:0] lvl);
    anc_addr = {AW'(node), lvl};
  endfunction

  function automatic logic [NODE_W-1:0] clamp_node(logic [NODE_W-1:0] node);
    clamp_node = (32'(node) < NODES) ? node : '0;
  endfunction

  // Request fields, out-of-range nodes fold onto the sentinel
  assign a_in = clamp_node(in_item.node_id);
  assign b_in = clamp_node(in_item.other_node);

  // Resolve the node pair from the read issued last cycle
  assign lift_take  = pend_r && (state_r == ST_Q_LIFT || state_r == ST_Q_CHK);
  assign joint_take = pend_r && (state_r == ST_Q_JOINT || state_r == ST_Q_FIN) &&
                      (am_rdata_a != am_rdata_b);
  assign hi_cur     = (lift_take || joint_take) ? am_rdata_a : hi_r;
  assign lo_cur     = joint_take ? am_rdata_b : lo_r;

  // Saturating depth for an inserted node
  assign d_ins = (dm_rdata >= DEPTH_CAP) ? DEPTH_CAP : dm_rdata + DEPTH_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.req_type == REQ_QUERY) begin
            state_nxt = (a_in == b_in) ? ST_DEP : ST_Q_DU;
          end else begin
            state_nxt = (a_in == '0) ? ST_OUT : ST_INS_RD;
          end
        end
      end
      ST_INS_RD:  state_nxt = ST_INS_WR;
      ST_INS_WR:  state_nxt = (LEVELS == 1) ? ST_OUT : ST_INS_LRD;
      ST_INS_LRD: state_nxt = ST_INS_LWR;
      ST_INS_LWR: state_nxt = (k_r == K_TOP) ? ST_OUT : ST_INS_LRD;
      ST_Q_DU:    state_nxt = ST_Q_DV;
      ST_Q_DV:    state_nxt = ST_Q_ORD;
      ST_Q_ORD:   state_nxt = ST_Q_LIFT;
      ST_Q_LIFT:  state_nxt = (k_r == '0) ? ST_Q_CHK : ST_Q_LIFT;
      ST_Q_CHK:   state_nxt = (hi_cur == lo_r) ? ST_DEP : ST_Q_JOINT;
      ST_Q_JOINT: state_nxt = (k_r == '0) ? ST_Q_FIN : ST_Q_JOINT;
      ST_Q_FIN:   state_nxt = ST_Q_RGET;
      ST_Q_RGET:  state_nxt = ST_DEP;
      ST_DEP:     state_nxt = ST_OUT;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory accesses per state
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    r_nxt         = r_r;
    du_nxt        = du_r;
    d_nxt         = d_r;
    diff_nxt      = diff_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    dsel_nxt      = dsel_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    dm_we         = 1'b0;
    dm_waddr      = AW'(a_r);
    dm_wdata      = d_ins;
    dm_raddr      = '0;
    am_we         = 1'b0;
    am_waddr      = anc_addr(a_r, k_r);
    am_wdata      = am_rdata_a;
    am_raddr_a    = '0;
    am_raddr_b    = '0;
    case (state_r)
      ST_IDLE: begin
        a_nxt = a_in;
        b_nxt = b_in;
        if (start) begin
          if (in_item.req_type == REQ_QUERY) begin
            r_nxt = a_in;
          end else begin
            // insert of the sentinel only echoes the parent
            r_nxt    = b_in;
            d_nxt    = '0;
            dsel_nxt = 1'b0;
          end
        end
      end
      ST_INS_RD: begin
        dm_raddr = AW'(b_r);
      end
      ST_INS_WR: begin
        // depth and level 0 of the new node
        dm_we    = 1'b1;
        am_we    = 1'b1;
        am_waddr = anc_addr(a_r, '0);
        am_wdata = b_r;
        hi_nxt   = b_r;
        k_nxt    = KW'(1);
        r_nxt    = b_r;
        d_nxt    = d_ins;
        dsel_nxt = 1'b0;
      end
      ST_INS_LRD: begin
        am_raddr_a = anc_addr(hi_r, k_r - KW'(1));
      end
      ST_INS_LWR: begin
        // level k is the level below of the level-below ancestor
        am_we    = 1'b1;
        am_waddr = anc_addr(a_r, k_r);
        am_wdata = am_rdata_a;
        hi_nxt   = am_rdata_a;
        k_nxt    = k_r + KW'(1);
      end
      ST_Q_DU: begin
        dm_raddr = AW'(a_r);
      end
      ST_Q_DV: begin
        dm_raddr = AW'(b_r);
        du_nxt   = dm_rdata;
      end
      ST_Q_ORD: begin
        // deeper node goes first
        if (du_r > dm_rdata) begin
          hi_nxt   = a_r;
          lo_nxt   = b_r;
          diff_nxt = LEVELS'(du_r - dm_rdata);
        end else begin
          hi_nxt   = b_r;
          lo_nxt   = a_r;
          diff_nxt = LEVELS'(dm_rdata - du_r);
        end
        k_nxt = K_TOP;
      end
      ST_Q_LIFT: begin
        hi_nxt = hi_cur;
        if (diff_r[k_r]) begin
          am_raddr_a = anc_addr(hi_cur, k_r);
          pend_nxt   = 1'b1;
        end
        k_nxt = k_r - KW'(1);
      end
      ST_Q_CHK: begin
        hi_nxt = hi_cur;
        r_nxt  = hi_cur;
        k_nxt  = K_TOP;
      end
      ST_Q_JOINT: begin
        // lift both while their ancestors differ
        hi_nxt     = hi_cur;
        lo_nxt     = lo_cur;
        am_raddr_a = anc_addr(hi_cur, k_r);
        am_raddr_b = anc_addr(lo_cur, k_r);
        pend_nxt   = 1'b1;
        k_nxt      = k_r - KW'(1);
      end
      ST_Q_FIN: begin
        hi_nxt     = hi_cur;
        am_raddr_a = anc_addr(hi_cur, '0);
      end
      ST_Q_RGET: begin
        r_nxt = am_rdata_a;
      end
      ST_DEP: begin
        dm_raddr = AW'(r_r);
        dsel_nxt = 1'b1;
      end
      ST_OUT: begin
        out_valid_nxt               = 1'b1;
        out_item_nxt.ancestor       = r_r;
        out_item_nxt.ancestor_depth = dsel_r ? dm_rdata : d_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    r_r        <= r_nxt;
    du_r       <= du_nxt;
    d_r        <= d_nxt;
    diff_r     <= diff_nxt;
    k_r        <= k_nxt;
    dsel_r     <= dsel_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[sv/binary_lifting_lca_table.sv]
// Top level of the binary-lifting lowest-common-ancestor table.
//
// A request is taken when start is high and busy is low; its single result
// shows on out_item for one cycle with out_valid high and cannot be held off,
// and the block is already idle in that cycle. A query of two equal nodes or
// an insert of node 0 skips the level walks. The time per request is set by
// the chain of dependent reads of the ancestor memory, whose read data is
// registered: an insert spends a read and a write per level, a query one step
// per level for the depth lift and one per level for the joint lift. Node 0
// is the sentinel and always reads as depth 0 with all ancestors 0; no
// clearing pass is needed after reset. Nodes must be inserted parent
// before child.
module binary_lifting_lca_table #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bllca_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output bllca_pkg::out_item_t out_item
);
  import bllca_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int KW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MW = AW + KW;

  logic               dm_we;
  logic [AW-1:0]      dm_waddr;
  logic [DEPTH_W-1:0] dm_wdata;
  logic [AW-1:0]      dm_raddr;
  logic [DEPTH_W-1:0] dm_rdata;
  logic               am_we;
  logic [MW-1:0]      am_waddr;
  logic [NODE_W-1:0]  am_wdata;
  logic [MW-1:0]      am_raddr_a;
  logic [NODE_W-1:0]  am_rdata_a;
  logic [MW-1:0]      am_raddr_b;
  logic [NODE_W-1:0]  am_rdata_b;

  // Sequencer
  bllca_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .dm_we      (dm_we),
    .dm_waddr   (dm_waddr),
    .dm_wdata   (dm_wdata),
    .dm_raddr   (dm_raddr),
    .dm_rdata   (dm_rdata),
    .am_we      (am_we),
    .am_waddr   (am_waddr),
    .am_wdata   (am_wdata),
    .am_raddr_a (am_raddr_a),
    .am_rdata_a (am_rdata_a),
    .am_raddr_b (am_raddr_b),
    .am_rdata_b (am_rdata_b)
  );

  // Node depths
  bllca_depth_mem #(
    .NODES (NODES)
  ) u_depth_mem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  // Ancestor table
  bllca_anc_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_anc_mem (
    .clk     (clk),
    .we      (am_we),
    .waddr   (am_waddr),
    .wdata   (am_wdata),
    .raddr_a (am_raddr_a),
    .rdata_a (am_rdata_a),
    .raddr_b (am_raddr_b),
    .rdata_b (am_rdata_b)
  );

endmodule

[sv/bllca_checker.sv]
// Port-level checks for the LCA table and their bind to the top level.
module bllca_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input bllca_pkg::out_item_t out_item
);
  import bllca_pkg::*;

  // Every accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result is shown only once the block has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each request ends with its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("block went idle without a result");

  // One result per request: strobes never stand back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Returned depths never pass the saturation point
  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.ancestor_depth <= DEPTH_CAP))
    else $error("result depth above the depth cap");

endmodule

bind binary_lifting_lca_table bllca_checker u_bllca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[bench/tb_binary_lifting_lca_table.sv]
// Self-checking testbench for the binary-lifting lowest-common-ancestor table.
module tb_binary_lifting_lca_table;
  timeunit 1ns;
  timeprecision 1ps;

  import bllca_pkg::*;

  localparam int NODES  = 1024;
  localparam int LEVELS = 10;
  localparam int N_RAND = 1725;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  binary_lifting_lca_table #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Shadow copy of the tree: depth per node and jump pointers 2^k levels up
  bit [DEPTH_W-1:0] depth_of [NODES];
  bit [NODE_W-1:0]  jump_up  [NODES][LEVELS];

  // Bookkeeping for legal stimulus: only written nodes may be read back
  bit              known [NODES];
  int unsigned     known_list [$];
  int unsigned     free_ids [$];
  logic [NODE_W-1:0] last_new;

  out_item_t   expected_lca_q [$];
  int unsigned errors;
  int unsigned n_insert;
  int unsigned n_query;
  int unsigned n_checked;
  int unsigned n_sent;
  int unsigned max_depth;
  int unsigned burst_left;
  int unsigned quiet_left;
  bit          quiet;

  // Directed rows: small trees whose answers can be read off by hand
  typedef struct packed {
    req_kind_t          kind;
    logic [NODE_W-1:0]  a;
    logic [NODE_W-1:0]  b;
    logic               typed;
    logic [NODE_W-1:0]  anc;
    logic [DEPTH_W-1:0] dep;
  } dir_row_t;

  localparam int N_DIR = 24;
  dir_row_t dir_tab [N_DIR] = '{
    '{REQ_QUERY,  10'd0,    10'd0,    1'b1, 10'd0,    11'd0}, // sentinel after reset
    '{REQ_INSERT, 10'd0,    10'd0,    1'b1, 10'd0,    11'd0}, // insert of node zero
    '{REQ_INSERT, 10'd1,    10'd0,    1'b1, 10'd0,    11'd1}, // root
    '{REQ_INSERT, 10'd2,    10'd1,    1'b1, 10'd1,    11'd2},
    '{REQ_INSERT, 10'd1023, 10'd2,    1'b1, 10'd2,    11'd3},
    '{REQ_INSERT, 10'd3,    10'd1,    1'b1, 10'd1,    11'd2},
    '{REQ_QUERY,  10'd2,    10'd3,    1'b1, 10'd1,    11'd1},
    '{REQ_QUERY,  10'd1023, 10'd3,    1'b1, 10'd1,    11'd1},
    '{REQ_QUERY,  10'd3,    10'd1023, 1'b1, 10'd1,    11'd1},
    '{REQ_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd1023, 11'd3}, // equal nodes
    '{REQ_QUERY,  10'd1023, 10'd0,    1'b1, 10'd0,    11'd0},
    '{REQ_QUERY,  10'd0,    10'd1023, 1'b1, 10'd0,    11'd0},
    '{REQ_QUERY,  10'd2,    10'd1023, 1'b1, 10'd2,    11'd2}, // one is ancestor of other
    '{REQ_INSERT, 10'd0,    10'd1023, 1'b1, 10'd1023, 11'd0}, // sentinel must not change
    '{REQ_QUERY,  10'd0,    10'd0,    1'b1, 10'd0,    11'd0},
    '{REQ_INSERT, 10'd512,  10'd1023, 1'b1, 10'd1023, 11'd4},
    '{REQ_INSERT, 10'd341,  10'd512,  1'b1, 10'd512,  11'd5},
    '{REQ_INSERT, 10'd682,  10'd0,    1'b1, 10'd0,    11'd1}, // second root
    '{REQ_QUERY,  10'd341,  10'd682,  1'b1, 10'd0,    11'd0}, // separate trees
    '{REQ_QUERY,  10'd341,  10'd3,    1'b1, 10'd1,    11'd1},
    '{REQ_INSERT, 10'd3,    10'd341,  1'b0, 10'd0,    11'd0}, // re-insert, moves node 3
    '{REQ_QUERY,  10'd3,    10'd2,    1'b0, 10'd0,    11'd0},
    '{REQ_INSERT, 10'd1,    10'd1,    1'b0, 10'd0,    11'd0}, // own parent: a cycle
    '{REQ_QUERY,  10'd1023, 10'd682,  1'b0, 10'd0,    11'd0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Expected result of one request; inserts update the shadow tree
  function automatic out_item_t lca_predict(in_item_t rq);
    out_item_t         r;
    logic [NODE_W-1:0] a, b, hi, lo;
    int unsigned       d;
    logic [DEPTH_W-1:0] diff;
    a = rq.node_id;
    b = rq.other_node;
    if (rq.req_type == REQ_INSERT) begin
      r.ancestor = b;
      r.ancestor_depth = '0;
      if (a != 0) begin
        d = depth_of[b] + 1;
        if (d > DEPTH_CAP) d = DEPTH_CAP;
        depth_of[a] = d[DEPTH_W-1:0];
        jump_up[a][0] = b;
        for (int k = 1; k < LEVELS; k++) jump_up[a][k] = jump_up[jump_up[a][k-1]][k-1];
        r.ancestor_depth = d[DEPTH_W-1:0];
        if (d > max_depth) max_depth = d;
      end
    end else begin
      hi = a;
      if (a != b) begin
        if (depth_of[a] > depth_of[b]) begin
          hi = a;
          lo = b;
        end else begin
          hi = b;
          lo = a;
        end
        // only the low LEVELS bits of the difference take part in the lift
        diff = depth_of[hi] - depth_of[lo];
        for (int k = LEVELS - 1; k >= 0; k--) if (diff[k]) hi = jump_up[hi][k];
        if (hi != lo) begin
          for (int k = LEVELS - 1; k >= 0; k--) begin
            if (jump_up[hi][k] != jump_up[lo][k]) begin
              hi = jump_up[hi][k];
              lo = jump_up[lo][k];
            end
          end
          hi = jump_up[hi][0];
        end
      end
      r.ancestor = hi;
      r.ancestor_depth = depth_of[hi];
    end
    return r;
  endfunction

  function automatic in_item_t mk(req_kind_t kind, logic [NODE_W-1:0] a,
                                  logic [NODE_W-1:0] b);
    in_item_t rq;
    rq.req_type = kind;
    rq.node_id = a;
    rq.other_node = b;
    return rq;
  endfunction

  // Random node that has been written, never the sentinel
  function automatic logic [NODE_W-1:0] any_known();
    return NODE_W'(known_list[$urandom_range(known_list.size() - 1)]);
  endfunction

  // Random readable node, the sentinel now and then
  function automatic logic [NODE_W-1:0] pick_known();
    if ($urandom_range(9) == 0) return '0;
    return any_known();
  endfunction

  function automatic logic [NODE_W-1:0] take_free_id();
    int unsigned idx;
    logic [NODE_W-1:0] id;
    idx = $urandom_range(free_ids.size() - 1);
    id = NODE_W'(free_ids[idx]);
    free_ids.delete(idx);
    return id;
  endfunction

  // Present one request from a falling edge until it is taken
  task automatic issue_request(input in_item_t rq, input logic typed,
                               input out_item_t typed_res);
    out_item_t model_res;
    start = 1'b1;
    in_item = rq;
    do @(posedge clk); while (busy);
    model_res = lca_predict(rq);
    expected_lca_q.insert(expected_lca_q.size(), typed ? typed_res : model_res);
    n_sent++;
    if (rq.req_type == REQ_INSERT) begin
      n_insert++;
      if (rq.node_id != 0 && !known[rq.node_id]) begin
        known[rq.node_id] = 1'b1;
        known_list.insert(known_list.size(), 32'(rq.node_id));
      end
    end else begin
      n_query++;
    end
    @(negedge clk);
  endtask

  // Bursts of requests with random gaps, and quiet stretches with none
  task automatic sender_gap();
    int unsigned gap;
    if (quiet_left == 0) begin
      quiet_left = $urandom_range(60, 150);
      quiet = ($urandom_range(3) == 0);
    end
    quiet_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(9))
        0, 1:    gap = 0;
        2, 3, 4: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 32);
      endcase
      if (!quiet && gap != 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Mixed traffic: grow trees, ask queries, and some odd requests
  task automatic random_step();
    int unsigned       roll;
    logic [NODE_W-1:0] nd, par, u;
    roll = $urandom_range(99);
    if (roll < 45) begin
      nd = (free_ids.size() != 0) ? take_free_id() : any_known();
      case ($urandom_range(9))
        0, 1, 2, 3:    par = last_new;
        4, 5, 6, 7:    par = pick_known();
        default:       par = '0;
      endcase
      issue_request(mk(REQ_INSERT, nd, par), 1'b0, '0);
      last_new = nd;
    end else if (roll < 85) begin
      u = pick_known();
      issue_request(mk(REQ_QUERY, u, ($urandom_range(6) == 0) ? u : pick_known()),
                    1'b0, '0);
    end else if (roll < 93) begin
      issue_request(mk(REQ_INSERT, any_known(), pick_known()), 1'b0, '0);
    end else begin
      // node zero ignores its parent, so any parent is fine here
      issue_request(mk(REQ_INSERT, '0, NODE_W'($urandom_range(NODES - 1))), 1'b0, '0);
    end
    sender_gap();
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_lca_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, ancestor %0d depth %0d", $time,
                 out_item.ancestor, out_item.ancestor_depth);
      end else begin
        want = expected_lca_q.pop_front();
        n_checked++;
        if (out_item.ancestor !== want.ancestor) begin
          errors++;
          $display("%0t: ancestor mismatch, expected %0d actual %0d", $time,
                   want.ancestor, out_item.ancestor);
        end
        if (out_item.ancestor_depth !== want.ancestor_depth) begin
          errors++;
          $display("%0t: ancestor_depth mismatch, expected %0d actual %0d", $time,
                   want.ancestor_depth, out_item.ancestor_depth);
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t          row;
    logic [NODE_W-1:0] tip, nd;
    int unsigned       sat_extra, n_phase3;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    last_new = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    for (int i = 0; i < N_DIR; i++) begin
      row = dir_tab[i];
      issue_request(mk(row.kind, row.a, row.b), row.typed, {row.anc, row.dep});
      sender_gap();
    end

    for (int i = 1; i < NODES; i++) if (!known[i]) free_ids.insert(free_ids.size(), i);
    last_new = 10'd1023;

    // random forest
    for (int i = 0; i < 400; i++) random_step();

    // hold off until the block has answered everything
    start = 1'b0;
    while (expected_lca_q.size() != 0) @(negedge clk);

    // one long chain from the deepest node, on past the depth limit;
    // queries against it see depth differences wider than the table
    tip = last_new;
    foreach (known_list[i]) begin
      if (depth_of[known_list[i]] > depth_of[tip]) tip = NODE_W'(known_list[i]);
    end
    sat_extra = 0;
    while (sat_extra < 8) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(2))
          0:       issue_request(mk(REQ_QUERY, tip, '0), 1'b0, '0);
          1:       issue_request(mk(REQ_QUERY, tip, pick_known()), 1'b0, '0);
          default: issue_request(mk(REQ_QUERY, pick_known(), tip), 1'b0, '0);
        endcase
      end else begin
        if (depth_of[tip] == DEPTH_CAP) sat_extra++;
        nd = (free_ids.size() != 0) ? take_free_id() : any_known();
        issue_request(mk(REQ_INSERT, nd, tip), 1'b0, '0);
        tip = nd;
      end
      sender_gap();
    end
    last_new = tip;

    // mixed traffic on the now tangled tree
    n_phase3 = 0;
    while (n_sent < N_DIR + N_RAND || n_phase3 < 100) begin
      random_step();
      n_phase3++;
    end

    start = 1'b0;
    while (expected_lca_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Ran %0d inserts and %0d queries, %0d results checked.",
             n_insert, n_query, n_checked);
    $display("Deepest node reached depth %0d; %0d nodes written.",
             max_depth, known_list.size());
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[binary_lifting_lca_table.f]
sv/bllca_pkg.sv
sv/bllca_depth_mem.sv
sv/bllca_anc_mem.sv
sv/bllca_ctrl.sv
sv/binary_lifting_lca_table.sv
sv/bllca_checker.sv
bench/tb_binary_lifting_lca_table.sv
